FILE: hw/rtl/rsgp_pkg.sv
// shared types, codes and constants for the ray set geometry precheck
package rsgp_pkg;

    // default store depth
    localparam int RSGP_MAX_RAYS = 16;

    // field widths
    localparam int ORG_W   = 24;
    localparam int DIR_W   = 16;
    localparam int CNT_W   = 5;
    localparam int DSQ_W   = 50;
    localparam int DOT_W   = 29;
    localparam int COS_W   = 15;
    localparam int STAT_W  = 3;
    localparam int IN_W    = 120;
    localparam int OUT_W   = 88;
    localparam int CFG_I_W = 2;
    localparam int CFG_D_W = 24;

    // 1.0 in Q1.28
    localparam logic [DOT_W-1:0] ONE_Q28 = DOT_W'(1) << 28;

    // configuration register indexes
    localparam logic [CFG_I_W-1:0] CFG_MIN_RAY_COUNT   = 2'd0;
    localparam logic [CFG_I_W-1:0] CFG_MIN_BASELINE_MM = 2'd1;
    localparam logic [CFG_I_W-1:0] CFG_COS_MIN_ANGLE   = 2'd2;

    // reset values of the ray count and angle configuration registers
    localparam logic [CNT_W-1:0]   RST_MIN_RAY_COUNT = 5'd2;
    localparam logic [COS_W-1:0]   RST_COS_MIN_ANGLE = 15'd16384;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_PASS     = 3'd0,
        ST_TOO_FEW  = 3'd1,
        ST_UNDER2   = 3'd2,
        ST_SHORT_BL = 3'd3,
        ST_NARROW   = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_STORE,
        S_OVF,
        S_FINISH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic issue;
        logic store;
        logic mark_ovf;
        logic finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic count_full;
        logic count_zero;
        logic last_issue;
        logic pipe_busy;
        logic in_last;
        logic out_free;
    } t_stat;

endpackage

FILE: hw/rtl/rsgp_ctrl.sv
// controller state machine: sequences capture, pair scan, store and report
module rsgp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  rsgp_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output rsgp_pkg::t_cmd  o_cmd
);
    import rsgp_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.count_full) begin
                        n_state = S_OVF;
                    end else if (i_stat.count_zero) begin
                        n_state = S_STORE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_STORE;
                end
            end
            S_STORE, S_OVF: begin
                n_state = i_stat.in_last ? S_FINISH : S_IDLE;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs, no input transfer while reset is held
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.load_in = i_in_valid & i_rst_n;
            end
            S_SCAN:   o_cmd.issue    = 1'b1;
            S_DRAIN:  o_cmd          = '0;
            S_STORE:  o_cmd.store    = 1'b1;
            S_OVF:    o_cmd.mark_ovf = 1'b1;
            S_FINISH: o_cmd.finish   = i_stat.out_free;
            default:  o_cmd          = '0;
        endcase
    end

endmodule

FILE: hw/rtl/rsgp_datapath.sv
// datapath: ray stores, pair pipeline, running extremes, checks and result register
module rsgp_datapath #(
    parameter int MAX_RAYS = rsgp_pkg::RSGP_MAX_RAYS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rsgp_pkg::t_cmd              i_cmd,
    output rsgp_pkg::t_stat             o_stat,
    input  logic [rsgp_pkg::IN_W-1:0]   i_in_data,
    input  logic                        i_in_last,
    input  logic                        i_cfg_we,
    input  logic [rsgp_pkg::CFG_I_W-1:0] i_cfg_idx,
    input  logic [rsgp_pkg::CFG_D_W-1:0] i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rsgp_pkg::OUT_W-1:0]  o_out_data
);
    import rsgp_pkg::*;

    localparam int IW = (MAX_RAYS > 1) ? $clog2(MAX_RAYS) : 1;
    localparam int CW = $clog2(MAX_RAYS + 1);
    localparam int TW = (CW > CNT_W) ? CW : CNT_W;

    // configuration
    logic [CNT_W-1:0]   r_min_ray_count;
    logic [ORG_W-1:0]   r_min_baseline;
    logic [2*ORG_W-1:0] r_min_baseline_sq;
    logic [COS_W-1:0]   r_cos_min_angle;

    // captured input ray
    logic signed [ORG_W-1:0] r_in_ox, r_in_oy, r_in_oz;
    logic signed [DIR_W-1:0] r_in_dx, r_in_dy, r_in_dz;
    logic                    r_in_last;

    // ray stores
    logic [ORG_W-1:0]   r_mem_ox  [MAX_RAYS];
    logic [ORG_W-1:0]   r_mem_oy  [MAX_RAYS];
    logic [ORG_W-1:0]   r_mem_oz  [MAX_RAYS];
    logic [3*DIR_W-1:0] r_mem_dir [MAX_RAYS];

    // set state
    logic [CW-1:0]    r_count;
    logic [IW-1:0]    r_idx;
    logic [DSQ_W-1:0] r_max_dsq;
    logic [DOT_W-1:0] r_min_dot;
    logic             r_ovf;

    // pipeline
    logic                    r_v0, r_v1, r_v2;
    logic signed [ORG_W-1:0] r_rd_ox, r_rd_oy, r_rd_oz;
    logic [3*DIR_W-1:0]      r_rd_dir;
    logic [2*ORG_W-1:0]      r_sqx, r_sqy, r_sqz;
    logic signed [31:0]      r_px, r_py, r_pz;
    logic [DSQ_W-1:0]        r_dsq;
    logic signed [33:0]      r_dot_sum;

    // result register
    logic             r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [CNT_W-1:0] r_out_total;
    logic [DSQ_W-1:0] r_out_max;
    logic [DOT_W-1:0] r_out_min;

    // combinational helpers
    logic signed [ORG_W:0]     w_dx, w_dy, w_dz;
    logic signed [2*ORG_W+1:0] w_sqx, w_sqy, w_sqz;
    logic signed [DIR_W-1:0]   w_sdx, w_sdy, w_sdz;
    logic [DOT_W-1:0]          w_abs_dot;
    logic signed [33:0]        w_neg_sum;
    t_status                   w_status;
    logic [TW-1:0]             w_count_t;
    logic [CNT_W-1:0]          w_total;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ray_count <= RST_MIN_RAY_COUNT;
            r_min_baseline  <= '0;
            r_cos_min_angle <= RST_COS_MIN_ANGLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_RAY_COUNT:   r_min_ray_count <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_BASELINE_MM: r_min_baseline  <= i_cfg_data[ORG_W-1:0];
                CFG_COS_MIN_ANGLE:   r_cos_min_angle <= i_cfg_data[COS_W-1:0];
                default: ;
            endcase
        end
    end

    // squared baseline threshold, registered from the baseline register
    always_ff @(posedge i_clk) begin
        r_min_baseline_sq <= r_min_baseline * r_min_baseline;
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_ox   <= i_in_data[ORG_W-1:0];
            r_in_oy   <= i_in_data[2*ORG_W-1:ORG_W];
            r_in_oz   <= i_in_data[3*ORG_W-1:2*ORG_W];
            r_in_dx   <= i_in_data[3*ORG_W+DIR_W-1:3*ORG_W];
            r_in_dy   <= i_in_data[3*ORG_W+2*DIR_W-1:3*ORG_W+DIR_W];
            r_in_dz   <= i_in_data[3*ORG_W+3*DIR_W-1:3*ORG_W+2*DIR_W];
            r_in_last <= i_in_last;
        end
    end

    // store write at the fill position, registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem_ox[r_count[IW-1:0]]  <= r_in_ox;
            r_mem_oy[r_count[IW-1:0]]  <= r_in_oy;
            r_mem_oz[r_count[IW-1:0]]  <= r_in_oz;
            r_mem_dir[r_count[IW-1:0]] <= {r_in_dz, r_in_dy, r_in_dx};
        end
        if (i_cmd.issue) begin
            r_rd_ox  <= r_mem_ox[r_idx];
            r_rd_oy  <= r_mem_oy[r_idx];
            r_rd_oz  <= r_mem_oz[r_idx];
            r_rd_dir <= r_mem_dir[r_idx];
        end
    end

    // stage 1: coordinate differences squared, direction products
    always_comb begin
        w_dx  = {r_in_ox[ORG_W-1], r_in_ox} - {r_rd_ox[ORG_W-1], r_rd_ox};
        w_dy  = {r_in_oy[ORG_W-1], r_in_oy} - {r_rd_oy[ORG_W-1], r_rd_oy};
        w_dz  = {r_in_oz[ORG_W-1], r_in_oz} - {r_rd_oz[ORG_W-1], r_rd_oz};
        w_sqx = w_dx * w_dx;
        w_sqy = w_dy * w_dy;
        w_sqz = w_dz * w_dz;
        w_sdx = r_rd_dir[DIR_W-1:0];
        w_sdy = r_rd_dir[2*DIR_W-1:DIR_W];
        w_sdz = r_rd_dir[3*DIR_W-1:2*DIR_W];
    end

    always_ff @(posedge i_clk) begin
        r_sqx <= w_sqx[2*ORG_W-1:0];
        r_sqy <= w_sqy[2*ORG_W-1:0];
        r_sqz <= w_sqz[2*ORG_W-1:0];
        r_px  <= 32'(r_in_dx) * 32'(w_sdx);
        r_py  <= 32'(r_in_dy) * 32'(w_sdy);
        r_pz  <= 32'(r_in_dz) * 32'(w_sdz);
    end

    // stage 2: sums
    always_ff @(posedge i_clk) begin
        r_dsq     <= DSQ_W'(r_sqx) + DSQ_W'(r_sqy) + DSQ_W'(r_sqz);
        r_dot_sum <= 34'(r_px) + 34'(r_py) + 34'(r_pz);
    end

    // stage 3: clamp to one and take magnitude
    always_comb begin
        w_neg_sum = -r_dot_sum;
        if ((r_dot_sum > $signed(34'(ONE_Q28))) || (w_neg_sum > $signed(34'(ONE_Q28)))) begin
            w_abs_dot = ONE_Q28;
        end else if (r_dot_sum < 0) begin
            w_abs_dot = w_neg_sum[DOT_W-1:0];
        end else begin
            w_abs_dot = r_dot_sum[DOT_W-1:0];
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load_in) begin
            r_idx <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // set state: count, extremes and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_count   <= '0;
            r_max_dsq <= '0;
            r_min_dot <= ONE_Q28;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.mark_ovf) begin
                r_ovf <= 1'b1;
            end
            if (r_v2 && (r_dsq > r_max_dsq)) begin
                r_max_dsq <= r_dsq;
            end
            if (r_v2 && (w_abs_dot < r_min_dot)) begin
                r_min_dot <= w_abs_dot;
            end
        end
    end

    // set checks in priority order
    always_comb begin
        w_count_t = TW'(r_count);
        w_total   = (w_count_t > TW'(31)) ? CNT_W'(31) : w_count_t[CNT_W-1:0];
        if (r_ovf) begin
            w_status = ST_OVERFLOW;
        end else if (w_count_t < TW'(r_min_ray_count)) begin
            w_status = ST_TOO_FEW;
        end else if (r_count < CW'(2)) begin
            w_status = ST_UNDER2;
        end else if (r_max_dsq < DSQ_W'(r_min_baseline_sq)) begin
            w_status = ST_SHORT_BL;
        end else if (r_min_dot > {r_cos_min_angle, 14'd0}) begin
            w_status = ST_NARROW;
        end else begin
            w_status = ST_PASS;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= w_status;
            r_out_total  <= w_total;
            r_out_max    <= r_max_dsq;
            r_out_min    <= r_min_dot;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.count_full = (r_count == CW'(MAX_RAYS));
        o_stat.count_zero = (r_count == '0);
        o_stat.last_issue = ((CW'(r_idx) + CW'(1)) == r_count);
        o_stat.pipe_busy  = r_v0 | r_v1 | r_v2;
        o_stat.in_last    = r_in_last;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {1'b0, r_out_min, r_out_max, r_out_total, r_out_status};

endmodule

FILE: hw/rtl/ray_set_geometry_precheck.sv
// top level of the ray set geometry precheck: controller, datapath and checks
//
//  channel   direction  handshake            payload
//  s         in         i_s_tvalid/o_s_tready i_s_tdata (ray), i_s_tlast (last_ray)
//  m         out        o_m_tvalid/i_m_tready o_m_tdata (status, totals)
//  cfg       in         i_cfg_we             i_cfg_idx, i_cfg_data
//
//  a ray that finds rays stored holds off the next transfer until it is handled: one store
//  read per stored ray through the three stage pair pipeline, a drain, then the store write;
//  an empty store takes only the store write, a full store only the overflow mark.
//  a last ray then loads the result register in a report step; the result waits there while
//  o_m_tready is low; the next set is taken in meanwhile.
//  reset is synchronous, active low, and empties the set and restores registers.
module ray_set_geometry_precheck #(
    parameter int MAX_RAYS = rsgp_pkg::RSGP_MAX_RAYS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from the lowest bit up
    input  logic [rsgp_pkg::IN_W-1:0]    i_s_tdata,
    input  logic                         i_s_tlast,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // status, ray_total, max_baseline_sq, min_abs_dot from the lowest bit up
    output logic [rsgp_pkg::OUT_W-1:0]   o_m_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    input  logic                         i_cfg_we,
    input  logic [rsgp_pkg::CFG_I_W-1:0] i_cfg_idx,
    input  logic [rsgp_pkg::CFG_D_W-1:0] i_cfg_data
);
    import rsgp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    rsgp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    rsgp_datapath #(
        .MAX_RAYS (MAX_RAYS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_s_tdata),
        .i_in_last   (i_s_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata)
    );

`ifndef SYNTHESIS
    // a result only appears after the report step
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_cmd.finish))
        else $error("result valid without report step");

    // report step always leaves a result pending
    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_m_tvalid)
        else $error("report step lost its result");

    // no new ray is taken while the store is being scanned
    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> !o_s_tready)
        else $error("input ready during pair scan");

    // a full store is never written
    a_no_store_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.store |-> !w_stat.count_full)
        else $error("store write past capacity");
`endif

endmodule
